// File: src/nfha_pkg.sv
// Shared constants and operation codes for the next-fit heap allocator.
package nfha_pkg;

   // Default heap geometry.
   localparam int HEAP_UNITS_DEF = 4096;
   localparam int UNIT_BYTES_DEF = 4;

   // Width of the byte count carried by an allocate request.
   localparam int BYTES_W = 16;

   // Operation codes of the func field.
   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   // Status codes of a result.
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

endpackage

// File: src/nfha_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module nfha_ram #(
   parameter int WIDTH = 13,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write, and a registered read whose data follows in the cycle after the address.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: src/next_fit_heap_allocator.sv
// Top level of the next-fit free-list heap allocator.
//
// Each transaction either allocates a block (func 0) or frees one (func 1) and
// returns exactly one result. The heap of HEAP_UNITS units is kept as a
// circular, address-ordered free list whose block headers (size and link)
// live in two RAMs with a registered read; a sentinel of size zero sits below
// unit 0 and a roving pointer starts each search. An allocation first turns
// the byte count into units by a multiplication with the reciprocal of
// UNIT_BYTES, then visits free blocks, each with one RAM read and then one
// compare, and finishes with one or two header writes; it fails with address
// 0 and status 1 when the request exceeds the heap or the list wraps without a
// fit. A free walks the list in the same way to its insertion point, then
// reads the freed block and its successor and writes back the coalesced
// headers. The walk length, and so the latency, depends on how fragmented the
// heap is. One transaction is in flight at a time; a finished result waits in
// the output register while the next request is taken. No clearing pass is
// needed after reset.
module next_fit_heap_allocator #(
   parameter int HEAP_UNITS = nfha_pkg::HEAP_UNITS_DEF,
   parameter int UNIT_BYTES = nfha_pkg::UNIT_BYTES_DEF,
   parameter int IDX_W      = $clog2(HEAP_UNITS + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_func,
   input  logic [nfha_pkg::BYTES_W-1:0] req_request_bytes,
   input  logic [IDX_W-1:0]            req_release_address,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [IDX_W-1:0]            rsp_granted_address,
   output logic                        rsp_status
);

   import nfha_pkg::*;

   localparam int ADDR_W = $clog2(HEAP_UNITS);
   localparam int NUM_W  = BYTES_W + 1;
   localparam int RCP_SH = NUM_W + $clog2(UNIT_BYTES);
   localparam int RCP_W  = NUM_W + 1;
   localparam int PRD_W  = NUM_W + RCP_W;
   localparam int QUO_W  = PRD_W - RCP_SH;
   localparam int ST_W   = $clog2(HEAP_UNITS + 3);
   localparam logic [IDX_W-1:0]   SENT  = IDX_W'(HEAP_UNITS);
   localparam logic [ST_W-1:0]    LIMIT = ST_W'(HEAP_UNITS + 2);
   localparam logic [IDX_W:0]     HEAP_X = (IDX_W + 1)'(HEAP_UNITS);
   localparam logic [RCP_W-1:0]   RCP_MUL = RCP_W'(((longint'(1) << RCP_SH) +
                                     longint'(UNIT_BYTES) - 1) / longint'(UNIT_BYTES));

   // Sequencer states.
   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_DIV     = 4'd1;
   localparam logic [3:0] ST_A_RD    = 4'd2;
   localparam logic [3:0] ST_A_CAP   = 4'd3;
   localparam logic [3:0] ST_A_TAIL  = 4'd4;
   localparam logic [3:0] ST_R_RD    = 4'd5;
   localparam logic [3:0] ST_R_CAP   = 4'd6;
   localparam logic [3:0] ST_BP_RD   = 4'd7;
   localparam logic [3:0] ST_BP_CAP  = 4'd8;
   localparam logic [3:0] ST_N_RD    = 4'd9;
   localparam logic [3:0] ST_N_CAP   = 4'd10;
   localparam logic [3:0] ST_W_BP    = 4'd11;
   localparam logic [3:0] ST_W_P     = 4'd12;
   localparam logic [3:0] ST_DONE    = 4'd13;

   // Address-order key: the sentinel comes first, a block at x has place x + 1.
   function automatic logic [IDX_W-1:0] order_key(input logic [IDX_W-1:0] x);
      order_key = (x >= SENT) ? '0 : x + IDX_W'(1);
   endfunction

   logic [3:0]       state_ff, state_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [IDX_W-1:0] units_ff, units_in;
   logic [IDX_W-1:0] cur_ff, cur_in;
   logic [IDX_W-1:0] prev_ff, prev_in;
   logic [IDX_W-1:0] start_ff, start_in;
   logic             first_ff, first_in;
   logic [ST_W-1:0]  steps_ff, steps_in;
   logic [IDX_W-1:0] bp_ff, bp_in;
   logic [IDX_W-1:0] n_ff, n_in;
   logic [IDX_W-1:0] size_p_ff, size_p_in;
   logic [IDX_W-1:0] size_bp_ff, size_bp_in;
   logic [IDX_W-1:0] size_n_ff, size_n_in;
   logic [IDX_W-1:0] link_n_ff, link_n_in;
   logic [IDX_W-1:0] rover_ff, rover_in;
   logic [IDX_W-1:0] slink_ff, slink_in;
   logic             size0_w_ff, size0_w_in;
   logic             link0_w_ff, link0_w_in;
   logic             rd_sent_ff, rd_sent_in;
   logic             rd_zero_ff, rd_zero_in;
   logic [IDX_W-1:0] gra_ff, gra_in;
   logic             sts_ff, sts_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0] rsp_gra_ff, rsp_gra_in;
   logic             rsp_sts_ff, rsp_sts_in;

   // RAM ports.
   logic              size_we, link_we, rd_en;
   logic [ADDR_W-1:0] size_wa, link_wa, rd_addr;
   logic [IDX_W-1:0]  size_wd, link_wd, size_rd, link_rd;
   logic [IDX_W-1:0]  rd_idx;

   // Decoded read results and walk terms.
   logic [IDX_W-1:0] cap_size, cap_link;
   logic [IDX_W:0]   p_end;
   logic             fit;
   logic [IDX_W-1:0] kb, kp, kn;
   logic             brk;
   logic [PRD_W-1:0] quo_prod;
   logic [QUO_W-1:0] quo;
   logic [NUM_W:0]   units_full;
   logic             merge_n, merge_p;
   logic [IDX_W-1:0] tail;

   nfha_ram #(.WIDTH(IDX_W), .DEPTH(HEAP_UNITS)) u_size_ram (
      .clock   (clock),
      .wr_en   (size_we),
      .wr_addr (size_wa),
      .wr_data (size_wd),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (size_rd)
   );

   nfha_ram #(.WIDTH(IDX_W), .DEPTH(HEAP_UNITS)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_wa),
      .wr_data (link_wd),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (link_rd)
   );

   // Read address by state; the sentinel is never read from RAM.
   always_comb begin
      unique case (state_ff)
         ST_BP_RD: rd_idx = bp_ff;
         ST_N_RD:  rd_idx = n_ff;
         default:  rd_idx = cur_ff;
      endcase
   end
   assign rd_addr = rd_idx[ADDR_W-1:0];
   assign rd_en   = ((state_ff == ST_A_RD) || (state_ff == ST_R_RD) ||
                     (state_ff == ST_BP_RD) || (state_ff == ST_N_RD)) && (rd_idx < SENT);

   // Header as seen after the read: sentinel, unwritten entry 0, or RAM data.
   always_comb begin
      if (rd_sent_ff) begin
         cap_size = '0;
         cap_link = slink_ff;
      end else begin
         cap_size = (rd_zero_ff && !size0_w_ff) ? SENT : size_rd;
         if (rd_zero_ff && !link0_w_ff) begin
            cap_link = SENT;
         end else begin
            cap_link = (link_rd >= SENT) ? SENT : link_rd;
         end
      end
   end

   // Fit test for allocation and insertion test for a free.
   assign p_end = {1'b0, cur_ff} + {1'b0, cap_size};
   assign fit   = (cur_ff != SENT) && (cap_size >= units_ff) && (p_end <= HEAP_X);
   assign tail  = cur_ff + (cap_size - units_ff);
   assign kb    = order_key(bp_ff);
   assign kp    = order_key(cur_ff);
   assign kn    = order_key(cap_link);
   assign brk   = ((kb > kp) && (kb < kn)) || ((kp >= kn) && ((kb > kp) || (kb < kn)));

   // Coalescing tests against the following and the preceding free block.
   assign merge_n = (n_ff != SENT) &&
                    (({1'b0, bp_ff} + {1'b0, size_bp_ff}) == {1'b0, n_ff});
   assign merge_p = (prev_ff != SENT) &&
                    (({1'b0, prev_ff} + {1'b0, size_p_ff}) == {1'b0, bp_ff});

   // Unit count: the rounded byte count times the scaled reciprocal of the unit size.
   assign quo_prod   = PRD_W'(num_ff) * PRD_W'(RCP_MUL);
   assign quo        = quo_prod[PRD_W-1:RCP_SH];
   assign units_full = (NUM_W + 1)'(quo) + (NUM_W + 1)'(1);

   // Sequencer.
   always_comb begin
      state_in   = state_ff;
      num_in     = num_ff;
      units_in   = units_ff;
      cur_in     = cur_ff;
      prev_in    = prev_ff;
      start_in   = start_ff;
      first_in   = first_ff;
      steps_in   = steps_ff;
      bp_in      = bp_ff;
      n_in       = n_ff;
      size_p_in  = size_p_ff;
      size_bp_in = size_bp_ff;
      size_n_in  = size_n_ff;
      link_n_in  = link_n_ff;
      rover_in   = rover_ff;
      slink_in   = slink_ff;
      gra_in     = gra_ff;
      sts_in     = sts_ff;
      rd_sent_in = (rd_idx == SENT);
      rd_zero_in = (rd_idx == '0);
      size_we    = 1'b0;
      size_wa    = cur_ff[ADDR_W-1:0];
      size_wd    = '0;
      link_we    = 1'b0;
      link_wa    = cur_ff[ADDR_W-1:0];
      link_wd    = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_gra_in   = rsp_gra_ff;
      rsp_sts_in   = rsp_sts_ff;

      unique case (state_ff)
         ST_IDLE: begin
            gra_in = '0;
            sts_in = STATUS_OK;
            if (req_valid) begin
               if (req_func == FUNC_ALLOC) begin
                  num_in   = NUM_W'(req_request_bytes) + NUM_W'(UNIT_BYTES - 1);
                  state_in = ST_DIV;
               end else if ((req_release_address != '0) &&
                            (req_release_address <= SENT)) begin
                  bp_in    = req_release_address - IDX_W'(1);
                  cur_in   = rover_ff;
                  steps_in = '0;
                  state_in = ST_R_RD;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end

         // Unit count ready; reject oversize requests, else start the search.
         ST_DIV: begin
            if (units_full > (NUM_W + 1)'(HEAP_UNITS)) begin
               sts_in   = STATUS_FAIL;
               state_in = ST_DONE;
            end else begin
               units_in = units_full[IDX_W-1:0];
               cur_in   = rover_ff;
               start_in = rover_ff;
               first_in = 1'b1;
               steps_in = '0;
               state_in = ST_A_RD;
            end
         end

         ST_A_RD: state_in = ST_A_CAP;

         // Visit one free block of the allocation search.
         ST_A_CAP: begin
            if (first_ff) begin
               prev_in  = cur_ff;
               cur_in   = cap_link;
               first_in = 1'b0;
               state_in = ST_A_RD;
            end else if (fit) begin
               rover_in = prev_ff;
               if (cap_size == units_ff) begin
                  if (prev_ff == SENT) begin
                     slink_in = cap_link;
                  end else begin
                     link_we = 1'b1;
                     link_wa = prev_ff[ADDR_W-1:0];
                     link_wd = cap_link;
                  end
                  gra_in   = cur_ff + IDX_W'(1);
                  state_in = ST_DONE;
               end else begin
                  size_we  = 1'b1;
                  size_wa  = cur_ff[ADDR_W-1:0];
                  size_wd  = cap_size - units_ff;
                  n_in     = tail;
                  state_in = ST_A_TAIL;
               end
            end else if ((cur_ff == start_ff) || (steps_ff == LIMIT)) begin
               sts_in   = STATUS_FAIL;
               state_in = ST_DONE;
            end else begin
               prev_in  = cur_ff;
               cur_in   = cap_link;
               steps_in = steps_ff + ST_W'(1);
               state_in = ST_A_RD;
            end
         end

         // Header of the tail that is handed out.
         ST_A_TAIL: begin
            size_we  = 1'b1;
            size_wa  = n_ff[ADDR_W-1:0];
            size_wd  = units_ff;
            gra_in   = n_ff + IDX_W'(1);
            state_in = ST_DONE;
         end

         ST_R_RD: state_in = ST_R_CAP;

         // Walk of a free towards the insertion point.
         ST_R_CAP: begin
            if (brk) begin
               prev_in   = cur_ff;
               n_in      = cap_link;
               size_p_in = cap_size;
               state_in  = ST_BP_RD;
            end else if (steps_ff == LIMIT) begin
               state_in = ST_DONE;
            end else begin
               cur_in   = cap_link;
               steps_in = steps_ff + ST_W'(1);
               state_in = ST_R_RD;
            end
         end

         ST_BP_RD: state_in = ST_BP_CAP;

         ST_BP_CAP: begin
            size_bp_in = cap_size;
            state_in   = (n_ff == SENT) ? ST_W_BP : ST_N_RD;
         end

         ST_N_RD: state_in = ST_N_CAP;

         ST_N_CAP: begin
            size_n_in = cap_size;
            link_n_in = cap_link;
            state_in  = ST_W_BP;
         end

         // Header of the freed block, merged with its successor if adjacent.
         ST_W_BP: begin
            link_we = 1'b1;
            link_wa = bp_ff[ADDR_W-1:0];
            size_wa = bp_ff[ADDR_W-1:0];
            if (merge_n) begin
               size_we    = 1'b1;
               size_wd    = size_bp_ff + size_n_ff;
               size_bp_in = size_bp_ff + size_n_ff;
               link_wd    = link_n_ff;
               n_in       = link_n_ff;
            end else begin
               link_wd = n_ff;
            end
            state_in = ST_W_P;
         end

         // Predecessor absorbs the block or links to it.
         ST_W_P: begin
            link_wa = prev_ff[ADDR_W-1:0];
            size_wa = prev_ff[ADDR_W-1:0];
            if (merge_p) begin
               size_we = 1'b1;
               size_wd = size_p_ff + size_bp_ff;
               link_we = 1'b1;
               link_wd = n_ff;
            end else if (prev_ff == SENT) begin
               slink_in = bp_ff;
            end else begin
               link_we = 1'b1;
               link_wd = bp_ff;
            end
            rover_in = prev_ff;
            state_in = ST_DONE;
         end

         // Hand the result to the output register once it is free.
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_gra_in   = gra_ff;
               rsp_sts_in   = sts_ff;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      size0_w_in = size0_w_ff || (size_we && (size_wa == '0));
      link0_w_in = link0_w_ff || (link_we && (link_wa == '0));
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rover_ff     <= SENT;
         slink_ff     <= '0;
         size0_w_ff   <= 1'b0;
         link0_w_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         steps_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rover_ff     <= rover_in;
         slink_ff     <= slink_in;
         size0_w_ff   <= size0_w_in;
         link0_w_ff   <= link0_w_in;
         rsp_valid_ff <= rsp_valid_in;
         steps_ff     <= steps_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      num_ff     <= num_in;
      units_ff   <= units_in;
      cur_ff     <= cur_in;
      prev_ff    <= prev_in;
      start_ff   <= start_in;
      first_ff   <= first_in;
      bp_ff      <= bp_in;
      n_ff       <= n_in;
      size_p_ff  <= size_p_in;
      size_bp_ff <= size_bp_in;
      size_n_ff  <= size_n_in;
      link_n_ff  <= link_n_in;
      rd_sent_ff <= rd_sent_in;
      rd_zero_ff <= rd_zero_in;
      gra_ff     <= gra_in;
      sts_ff     <= sts_in;
      rsp_gra_ff <= rsp_gra_in;
      rsp_sts_ff <= rsp_sts_in;
   end

   assign req_stall           = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_granted_address = rsp_gra_ff;
   assign rsp_status          = rsp_sts_ff;

   // A new result appears only when the sequencer finishes a transaction.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result appeared outside the finishing state");

   // The roving pointer and the sentinel link always name a block or the sentinel.
   a_rover_range: assert property (@(posedge clock) disable iff (reset)
      (rover_ff <= SENT) && (slink_ff <= SENT))
      else $error("roving pointer or sentinel link out of range");

   // A failed allocation never hands out an address.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_sts_ff == STATUS_FAIL)) |-> (rsp_gra_ff == '0))
      else $error("failed allocation carries an address");

   // The walk counter never passes its bound.
   a_steps_bound: assert property (@(posedge clock) disable iff (reset)
      steps_ff <= LIMIT)
      else $error("walk counter beyond its bound");

endmodule
